// File: rtl/sicd_pkg.sv
`default_nettype none

package sicd_pkg;

   localparam int POS_W   = 12;
   localparam int DROP_W  = 9;
   localparam int CMD_W   = 3;
   localparam int COUNT_W = 13;
   localparam int PCNT_W  = 13;
   localparam int PTOT_W  = 14;
   localparam int PIDX_W  = 2;
   localparam int COIL_W  = 4;
   localparam int REM_CNT_W = $clog2(POS_W + 1);

   localparam logic [POS_W-1:0]  DEFAULT_REV_STEPS = POS_W'(512);
   localparam logic [POS_W-1:0]  MAX_REV_STEPS     = POS_W'(4095);
   localparam logic [DROP_W-1:0] DEFAULT_DROP_STEPS = DROP_W'(512 / 8);

   // Reciprocals for the divisions by 12 and by 13.
   localparam logic [9:0]  RECIP_3  = 10'd683;   // (x * 683) >> 11 == x / 3 for x < 1024
   localparam logic [12:0] RECIP_13 = 13'd5042;  // (x * 5042) >> 16 == x / 13 for x < 4096

   localparam logic [CMD_W-1:0] FN_TICK      = 3'd0;
   localparam logic [CMD_W-1:0] FN_ROTATE    = 3'd1;
   localparam logic [CMD_W-1:0] FN_CALIBRATE = 3'd2;
   localparam logic [CMD_W-1:0] FN_DISPENSE  = 3'd3;
   localparam logic [CMD_W-1:0] FN_REALIGN   = 3'd4;

   typedef enum logic [8:0] {
      PH_IDLE       = 9'b000000001,
      PH_ROTATE     = 9'b000000010,
      PH_CAL_HIGH   = 9'b000000100,
      PH_CAL_LOW    = 9'b000001000,
      PH_CAL_TRIM   = 9'b000010000,
      PH_DROP       = 9'b000100000,
      PH_RA_BACK    = 9'b001000000,
      PH_RA_FWD     = 9'b010000000,
      PH_RA_RESTORE = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rem_stat_type;

   function automatic logic [COIL_W-1:0] coil_of(input logic [2:0] idx);
      logic [COIL_W-1:0] pat;
      case (idx)
         3'd0: pat = 4'h1;
         3'd1: pat = 4'h3;
         3'd2: pat = 4'h2;
         3'd3: pat = 4'h6;
         3'd4: pat = 4'h4;
         3'd5: pat = 4'hC;
         3'd6: pat = 4'h8;
         3'd7: pat = 4'h9;
         default: pat = 4'h0;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

// File: rtl/sicd_rem.sv
`default_nettype none

module sicd_rem (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [sicd_pkg::POS_W-1:0]  num,
   input  wire logic [sicd_pkg::POS_W-1:0]  den,
   output      sicd_pkg::rem_stat_type      stat,
   output      logic [sicd_pkg::POS_W-1:0]  rem_next
);
   import sicd_pkg::*;

   logic [POS_W-1:0]     rem_ff, rem_in;
   logic [POS_W-1:0]     num_ff, num_in;
   logic [POS_W-1:0]     den_ff, den_in;
   logic [REM_CNT_W-1:0] cnt_ff, cnt_in;
   logic [POS_W:0]       trial;
   logic                 fits;

   // Restoring remainder, one dividend bit per cycle, most significant first.
   assign trial    = {rem_ff, num_ff[POS_W-1]};
   assign fits     = trial >= {1'b0, den_ff};
   assign rem_next = fits ? POS_W'(trial - {1'b0, den_ff}) : trial[POS_W-1:0];

   assign stat.busy = cnt_ff != '0;
   assign stat.done = cnt_ff == REM_CNT_W'(1);

   always_comb begin
      rem_in = rem_ff;
      num_in = num_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         num_in = num;
         den_in = den;
         cnt_in = REM_CNT_W'(POS_W);
      end else if (stat.busy) begin
         rem_in = rem_next;
         num_in = {num_ff[POS_W-2:0], 1'b0};
         cnt_in = cnt_ff - REM_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

endmodule

`default_nettype wire

// File: rtl/stepper_index_calibrating_driver.sv
`default_nettype none

// Half-step stepper driver with index calibration. Each accepted item is one step tick
// and produces exactly one result item holding the coil drive, position and status after
// that tick; at most one motor step is made per tick. Items are normally taken at one per
// clock cycle, the result register being refilled while the previous result is taken.
// The exception is the span after the tick that ends a calibration measurement and after
// the tick that ends a realign: a bit-serial remainder unit then reduces the position
// modulo the revolution length, and no item is accepted until it finishes.

module stepper_index_calibrating_driver (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [sicd_pkg::CMD_W-1:0]    req_func,
   input  wire logic signed [sicd_pkg::COUNT_W-1:0] req_step_count,
   input  wire logic                          req_sensor_level,
   input  wire logic [sicd_pkg::POS_W-1:0]    req_saved_step,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [sicd_pkg::COIL_W-1:0]   rsp_coil_pattern,
   output      logic [sicd_pkg::POS_W-1:0]    rsp_position,
   output      logic                          rsp_busy_res,
   output      logic                          rsp_calibrated,
   output      logic [sicd_pkg::POS_W-1:0]    rsp_revolution_steps,
   output      logic [sicd_pkg::DROP_W-1:0]   rsp_drop_steps
);
   import sicd_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   posm_ff, posm_in;
   logic [POS_W-1:0]   rev_ff, rev_in;
   logic [DROP_W-1:0]  drop_ff, drop_in;
   logic               cal_ff, cal_in;
   logic [POS_W-1:0]   left_ff, left_in;
   logic               back_ff, back_in;
   logic [PIDX_W-1:0]  pidx_ff, pidx_in;
   logic [PCNT_W-1:0]  pcnt_ff, pcnt_in;
   logic [PTOT_W-1:0]  ptot_ff, ptot_in;
   logic [POS_W-1:0]   target_ff, target_in;
   logic               pend_ff, pend_in;
   logic [COIL_W-1:0]  coil_ff, coil_in;
   logic               rsp_valid_ff;

   logic               accept;
   logic               rem_start;
   rem_stat_type       rem_stat;
   logic [POS_W-1:0]   rem_val;

   logic [POS_W-1:0]   fwd_pos;
   logic [POS_W-1:0]   bwd_pos;
   logic               step_en;
   logic               step_back;
   logic [POS_W-1:0]   step_pos;
   logic               seg_done;
   logic [COUNT_W-1:0] count_raw;
   logic [COUNT_W-1:0] count_mag;
   logic [PTOT_W:0]    tot_sum;
   logic [PTOT_W-1:0]  tot_half;
   logic [POS_W-1:0]   new_rev;
   logic [POS_W+12:0]  rev13_prod;
   logic [19:0]        rev12_prod;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rem_stat.busy && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   // The stepping position is always below the revolution length here.
   assign fwd_pos  = (posm_ff + POS_W'(1) == rev_ff) ? '0 : posm_ff + POS_W'(1);
   assign bwd_pos  = (posm_ff == '0) ? rev_ff - POS_W'(1) : posm_ff - POS_W'(1);
   assign step_pos = step_back ? bwd_pos : fwd_pos;

   assign count_raw  = req_step_count;
   assign count_mag  = count_raw[COUNT_W-1] ? COUNT_W'(0) - count_raw : count_raw;

   assign rev12_prod = {10'd0, rev_ff[POS_W-1:2]} * {10'd0, RECIP_3};

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      posm_in   = posm_ff;
      rev_in    = rev_ff;
      drop_in   = drop_ff;
      cal_in    = cal_ff;
      left_in   = left_ff;
      back_in   = back_ff;
      pidx_in   = pidx_ff;
      pcnt_in   = pcnt_ff;
      ptot_in   = ptot_ff;
      target_in = target_ff;
      pend_in   = pend_ff;
      coil_in   = coil_ff;
      step_en   = 1'b0;
      step_back = 1'b0;
      seg_done  = 1'b0;
      rem_start = 1'b0;
      tot_sum   = {1'b0, ptot_ff};
      tot_half  = '0;
      new_rev   = rev_ff;
      rev13_prod = '0;

      if (phase_ff == PH_IDLE) begin
         case (req_func)
            FN_TICK: begin
            end
            FN_ROTATE: begin
               if (count_raw != '0) begin
                  back_in  = count_raw[COUNT_W-1];
                  left_in  = count_mag[COUNT_W-1] ? MAX_REV_STEPS : count_mag[POS_W-1:0];
                  phase_in = PH_ROTATE;
               end
            end
            FN_CALIBRATE: begin
               pend_in  = 1'b0;
               pidx_in  = '0;
               pcnt_in  = '0;
               ptot_in  = '0;
               back_in  = 1'b0;
               phase_in = PH_CAL_HIGH;
            end
            FN_DISPENSE: begin
               if (cal_ff) begin
                  pend_in  = 1'b0;
                  back_in  = 1'b0;
                  left_in  = {{(POS_W-DROP_W){1'b0}}, drop_ff};
                  phase_in = PH_DROP;
               end else begin
                  pend_in  = 1'b1;
                  pidx_in  = '0;
                  pcnt_in  = '0;
                  ptot_in  = '0;
                  back_in  = 1'b0;
                  phase_in = PH_CAL_HIGH;
               end
            end
            FN_REALIGN: begin
               if (cal_ff) begin
                  target_in = req_saved_step;
                  phase_in  = PH_RA_BACK;
               end
            end
            default: begin
            end
         endcase
      end

      case (phase_in)
         PH_ROTATE, PH_CAL_TRIM, PH_DROP, PH_RA_FWD, PH_RA_RESTORE: begin
            if (left_in != '0) begin
               step_en   = 1'b1;
               step_back = back_in;
               left_in   = left_in - POS_W'(1);
               seg_done  = left_in == '0;
            end else begin
               seg_done = 1'b1;
            end
         end
         PH_CAL_HIGH: begin
            if (req_sensor_level) begin
               step_en = 1'b1;
               if (pcnt_in != '1) begin
                  pcnt_in = pcnt_in + PCNT_W'(1);
               end
            end else begin
               phase_in = PH_CAL_LOW;
            end
         end
         PH_CAL_LOW: begin
            if (!req_sensor_level) begin
               step_en = 1'b1;
               if (pcnt_in != '1) begin
                  pcnt_in = pcnt_in + PCNT_W'(1);
               end
            end else begin
               if (pidx_in != '0) begin
                  tot_sum = {1'b0, ptot_in} + (PTOT_W+1)'(pcnt_in);
                  ptot_in = tot_sum[PTOT_W] ? '1 : tot_sum[PTOT_W-1:0];
               end
               if (pidx_in[1]) begin
                  // Average of the two kept passes, clamped to a usable length.
                  tot_half = ptot_in >> 1;
                  if (tot_half > PTOT_W'(MAX_REV_STEPS)) begin
                     new_rev = MAX_REV_STEPS;
                  end else if (tot_half == '0) begin
                     new_rev = POS_W'(1);
                  end else begin
                     new_rev = tot_half[POS_W-1:0];
                  end
                  rev13_prod = {13'd0, new_rev} * {12'd0, RECIP_13};
                  rev_in    = new_rev;
                  drop_in   = new_rev[POS_W-1:3];
                  cal_in    = 1'b1;
                  back_in   = 1'b0;
                  left_in   = {3'd0, rev13_prod[POS_W+12:16]};
                  phase_in  = PH_CAL_TRIM;
                  rem_start = 1'b1;
               end else begin
                  pidx_in  = pidx_in + PIDX_W'(1);
                  pcnt_in  = '0;
                  phase_in = PH_CAL_HIGH;
               end
            end
         end
         PH_RA_BACK: begin
            if (req_sensor_level) begin
               step_en   = 1'b1;
               step_back = 1'b1;
            end else begin
               back_in  = 1'b0;
               left_in  = {3'd0, rev12_prod[19:11]};
               phase_in = PH_RA_FWD;
            end
         end
         default: begin
         end
      endcase

      if (step_en) begin
         pos_in  = step_pos;
         posm_in = step_pos;
         coil_in = coil_of(step_pos[2:0]);
      end

      if (seg_done) begin
         case (phase_in)
            PH_CAL_TRIM: begin
               pos_in  = '0;
               posm_in = '0;
               if (pend_in) begin
                  pend_in  = 1'b0;
                  back_in  = 1'b0;
                  left_in  = {{(POS_W-DROP_W){1'b0}}, drop_in};
                  phase_in = PH_DROP;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_RA_FWD: begin
               left_in  = target_in;
               back_in  = 1'b0;
               phase_in = PH_RA_RESTORE;
            end
            PH_RA_RESTORE: begin
               // The restored position may lie beyond the revolution length.
               pos_in    = target_in;
               phase_in  = PH_IDLE;
               rem_start = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   sicd_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && rem_start),
      .num      (pos_in),
      .den      (rev_in),
      .stat     (rem_stat),
      .rem_next (rem_val)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pos_ff       <= '0;
         posm_ff      <= '0;
         rev_ff       <= DEFAULT_REV_STEPS;
         drop_ff      <= DEFAULT_DROP_STEPS;
         cal_ff       <= 1'b0;
         left_ff      <= '0;
         back_ff      <= 1'b0;
         pidx_ff      <= '0;
         pcnt_ff      <= '0;
         ptot_ff      <= '0;
         target_ff    <= '0;
         pend_ff      <= 1'b0;
         coil_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            rev_ff    <= rev_in;
            drop_ff   <= drop_in;
            cal_ff    <= cal_in;
            left_ff   <= left_in;
            back_ff   <= back_in;
            pidx_ff   <= pidx_in;
            pcnt_ff   <= pcnt_in;
            ptot_ff   <= ptot_in;
            target_ff <= target_in;
            pend_ff   <= pend_in;
            coil_ff   <= coil_in;
         end
         if (rem_stat.done) begin
            posm_ff <= rem_val;
         end else if (accept) begin
            posm_ff <= posm_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_coil_pattern     <= coil_in;
         rsp_position         <= pos_in;
         rsp_busy_res         <= phase_in != PH_IDLE;
         rsp_calibrated       <= cal_in;
         rsp_revolution_steps <= rev_in;
         rsp_drop_steps       <= drop_in;
      end
   end

endmodule

`default_nettype wire
